>>> rtl/fcpd_pkg.sv
// Package for the FM cell-pair decoder: payload types, cell and alignment codes, constants.
`default_nettype none

package fcpd_pkg;

  // Error counter width and saturation limit
  localparam int unsigned ERR_BITS = 24;
  localparam logic [ERR_BITS-1:0] ERR_MAX = {ERR_BITS{1'b1}};

  // Output field width of the error counts
  localparam int unsigned ERR_OUT_BITS = 24;

  // Cells per raw word and width of a per-word error tally
  localparam int unsigned CELLS = 8;
  localparam int unsigned TALLY_BITS = $clog2(CELLS + 1);

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  // Raw 2-bit cell patterns
  typedef enum logic [1:0] {
    CELL_ZERO   = 2'b00,
    CELL_CLK_HI = 2'b01,
    CELL_CLK_LO = 2'b10,
    CELL_ONE    = 2'b11
  } cell_e;

  // Cell alignment state
  typedef enum logic [1:0] {
    ALIGN_NONE = 2'd0,
    ALIGN_HI   = 2'd1,
    ALIGN_LO   = 2'd2
  } align_e;

  // Input beat
  typedef struct packed {
    logic [15:0] raw_word;
    logic        first_word;
  } fcpd_in_t;

  // Output beat
  typedef struct packed {
    logic [7:0]              decoded_byte;
    logic [ERR_OUT_BITS-1:0] zero_errors;
    logic [ERR_OUT_BITS-1:0] one_errors;
  } fcpd_out_t;

  // Classified word handed from front to back
  typedef struct packed {
    cell_e [CELLS-1:0] kind;
    logic  [7:0]       data;
    logic              first_word;
  } fcpd_word_t;

  // Fit an error count onto the output field width
  function automatic logic [ERR_OUT_BITS-1:0] err_out(input logic [ERR_BITS-1:0] cnt);
    logic [ERR_BITS+ERR_OUT_BITS-1:0] wide;
    wide = {{ERR_OUT_BITS{1'b0}}, cnt};
    return wide[ERR_OUT_BITS-1:0];
  endfunction

  // Saturating add of a per-word tally
  function automatic logic [ERR_BITS-1:0] sat_add(input logic [ERR_BITS-1:0]   cnt,
                                                  input logic [TALLY_BITS-1:0] inc);
    logic [ERR_BITS:0] sum;
    sum = {1'b0, cnt} + {{(ERR_BITS+1-TALLY_BITS){1'b0}}, inc};
    if (sum > {1'b0, ERR_MAX}) begin
      return ERR_MAX;
    end
    return sum[ERR_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/fcpd_front.sv
// Front stage: accept raw words, split them into cells and decode the data bits.
`default_nettype none

module fcpd_front import fcpd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire fcpd_in_t   in_data_i,
  output logic            push_valid_o,
  input  wire logic       push_ready_i,
  output fcpd_word_t      push_data_o
);

  logic       valid_q, valid_d;
  fcpd_word_t word_q, word_d;
  logic       take;

  // Take a new beat whenever the stage is empty or its word moves on
  assign in_ready_o = !valid_q || push_ready_i;
  assign take = in_valid_i && in_ready_o;

  // Classify each cell, least significant cell first
  always_comb begin
    word_d.first_word = in_data_i.first_word;
    for (int i = 0; i < CELLS; i++) begin
      word_d.kind[i] = cell_e'(in_data_i.raw_word[2*i +: 2]);
      word_d.data[i] = &in_data_i.raw_word[2*i +: 2];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the payload until it moves on
  always_ff @(posedge clk_i) begin
    if (take) begin
      word_q <= word_d;
    end
  end

  assign push_valid_o = valid_q;
  assign push_data_o  = word_q;

endmodule

`default_nettype wire

>>> rtl/fcpd_queue.sv
// Short queue of classified words between the front and back stages.
`default_nettype none

module fcpd_queue import fcpd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       wr_valid_i,
  output logic            wr_ready_o,
  input  wire fcpd_word_t wr_data_i,
  output logic            rd_valid_o,
  input  wire logic       rd_ready_i,
  output fcpd_word_t      rd_data_o
);

  fcpd_word_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_BITS-1:0] cnt_q, cnt_d;
  logic                      push, pop;

  localparam logic [QUEUE_PTR_BITS-1:0] PtrLast = QUEUE_PTR_BITS'(QUEUE_DEPTH - 1);
  localparam logic [QUEUE_CNT_BITS-1:0] CntFull = QUEUE_CNT_BITS'(QUEUE_DEPTH);

  assign wr_ready_o = (cnt_q != CntFull);
  assign rd_valid_o = (cnt_q != '0);
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rd_ptr_q];

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/fcpd_back.sv
// Back stage: run the alignment tracker over the cells, update error counts, register results.
`default_nettype none

module fcpd_back import fcpd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       pop_valid_i,
  output logic            pop_ready_o,
  input  wire fcpd_word_t pop_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output fcpd_out_t       out_data_o
);

  align_e              align_q, align_d;
  logic                prev_q, prev_d;
  logic [ERR_BITS-1:0] zcnt_q, zcnt_d;
  logic [ERR_BITS-1:0] ocnt_q, ocnt_d;
  logic                out_valid_q, out_valid_d;
  fcpd_out_t           out_q, out_d;
  logic                take;

  align_e              align;
  logic                prev;
  logic [ERR_BITS-1:0] zbase, obase;
  logic [TALLY_BITS-1:0] ztally, otally;

  // Take a word when the result register is empty or being drained
  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign take = pop_valid_i && pop_ready_o;

  // Walk the eight cells, first cell first, tallying errors
  always_comb begin
    align  = pop_data_i.first_word ? ALIGN_NONE : align_q;
    prev   = pop_data_i.first_word ? 1'b1 : prev_q;
    zbase  = pop_data_i.first_word ? '0 : zcnt_q;
    obase  = pop_data_i.first_word ? '0 : ocnt_q;
    ztally = '0;
    otally = '0;
    for (int i = CELLS - 1; i >= 0; i--) begin
      case (pop_data_i.kind[i])
        CELL_ZERO: begin
          ztally = ztally + 1'b1;
          prev   = 1'b0;
        end
        CELL_CLK_HI: begin
          if (align == ALIGN_LO) begin
            if (!prev) begin
              ztally = ztally + 1'b1;
            end else begin
              otally = otally + 1'b1;
            end
          end
          align = ALIGN_HI;
          prev  = 1'b0;
        end
        CELL_CLK_LO: begin
          if (align == ALIGN_HI) begin
            otally = otally + 1'b1;
          end
          align = ALIGN_LO;
          prev  = 1'b0;
        end
        default: begin
          prev = 1'b1;
        end
      endcase
    end
  end

  // Next state and result
  always_comb begin
    align_d     = align_q;
    prev_d      = prev_q;
    zcnt_d      = zcnt_q;
    ocnt_d      = ocnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (take) begin
      align_d     = align;
      prev_d      = prev;
      zcnt_d      = sat_add(zbase, ztally);
      ocnt_d      = sat_add(obase, otally);
      out_valid_d = 1'b1;
      out_d.decoded_byte = pop_data_i.data;
      out_d.zero_errors  = err_out(zcnt_d);
      out_d.one_errors   = err_out(ocnt_d);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      align_q     <= ALIGN_NONE;
      prev_q      <= 1'b1;
      zcnt_q      <= '0;
      ocnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      align_q     <= align_d;
      prev_q      <= prev_d;
      zcnt_q      <= zcnt_d;
      ocnt_q      <= ocnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> rtl/fm_cell_pair_decoder.sv
// Top level of the FM cell-pair decoder: front stage, queue and back stage.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) takes one 16-bit raw FM
//   word per beat, first raw byte in bits 15..8, plus a first_word flag that
//   restarts cell alignment, the last bit and both error counts for a new buffer.
//   Output channel (out_valid_o / out_ready_i / out_data_o) gives one beat per
//   input beat: the decoded byte (first cell in bit 7) and the running,
//   saturating counts of unexpected zeros and of unexpected ones or slips.
//   Path: an input beat passes through the front register, the queue and the
//   result register before it shows as output valid. Throughput: one word per
//   cycle while the receiver keeps out_ready_i high; the back stage resolves
//   all eight cells of a word at once against the stored alignment state.
//   Reset: all stages empty, alignment unaligned, last bit 1, counts zero.
//   Receiver stall: the result register holds; the queue and the front
//   register absorb up to three more words before in_ready_o drops.
`default_nettype none

module fm_cell_pair_decoder import fcpd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire fcpd_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output fcpd_out_t      out_data_o
);

  logic       push_valid, push_ready;
  fcpd_word_t push_data;
  logic       pop_valid, pop_ready;
  fcpd_word_t pop_data;

  fcpd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  fcpd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_data_i  (push_data),
    .rd_valid_o (pop_valid),
    .rd_ready_i (pop_ready),
    .rd_data_o  (pop_data)
  );

  fcpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> sim/tb_fm_cell_pair_decoder.sv
// Self-checking testbench for the FM cell-pair decoder: directed and random words.
`default_nettype none

module tb_fm_cell_pair_decoder import fcpd_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned HOLD_CYCLES   = 100;
  localparam int unsigned HOLD_AT_BEAT  = 150;
  localparam int unsigned QUIET_FIRST   = 350;
  localparam int unsigned QUIET_LAST    = 450;
  localparam int unsigned RANDOM_WORDS  = 540;
  localparam int unsigned DRAIN_CYCLES  = 10;
  localparam int unsigned MAX_PRINTS    = 30;

  // Clock, reset and DUT ports
  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  fcpd_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  fcpd_out_t out_data_o;

  fm_cell_pair_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Words waiting to be driven, decoded results waiting to be seen
  fcpd_in_t  pending_words[$];
  fcpd_out_t expected_results[$];

  int unsigned in_beats    = 0;
  int unsigned out_beats   = 0;
  int unsigned issued      = 0;
  int unsigned buffers     = 0;
  int unsigned mismatches  = 0;
  int unsigned cycles      = 0;
  int unsigned hold_left   = 0;
  logic        hold_done   = 1'b0;

  // Decoder state mirrored by the testbench
  align_e              cell_align;
  logic                last_bit;
  logic [ERR_BITS-1:0] zero_total;
  logic [ERR_BITS-1:0] one_total;

  function automatic void restart_buffer();
    cell_align = ALIGN_NONE;
    last_bit   = 1'b1;
    zero_total = '0;
    one_total  = '0;
  endfunction

  function automatic logic [ERR_BITS-1:0] bump_count(logic [ERR_BITS-1:0] cnt);
    return (cnt == ERR_MAX) ? cnt : cnt + 1'b1;
  endfunction

  // Walk the eight cells of a word, most significant first, and update the state
  function automatic fcpd_out_t decode_word(fcpd_in_t w);
    fcpd_out_t   res;
    logic [7:0]  data;
    logic [63:0] zwide;
    logic [63:0] owide;
    cell_e       c;
    if (w.first_word) restart_buffer();
    data = '0;
    for (int i = CELLS - 1; i >= 0; i--) begin
      c = cell_e'(w.raw_word[2*i +: 2]);
      case (c)
        CELL_ZERO: begin
          zero_total = bump_count(zero_total);
          last_bit   = 1'b0;
        end
        CELL_CLK_HI: begin
          if (cell_align == ALIGN_LO) begin
            if (last_bit == 1'b0) zero_total = bump_count(zero_total);
            else one_total = bump_count(one_total);
          end
          cell_align = ALIGN_HI;
          last_bit   = 1'b0;
        end
        CELL_CLK_LO: begin
          if (cell_align == ALIGN_HI) one_total = bump_count(one_total);
          cell_align = ALIGN_LO;
          last_bit   = 1'b0;
        end
        default: begin
          last_bit = 1'b1;
        end
      endcase
      data = {data[6:0], last_bit};
    end
    zwide = 64'(zero_total);
    owide = 64'(one_total);
    res.decoded_byte = data;
    res.zero_errors  = zwide[ERR_OUT_BITS-1:0];
    res.one_errors   = owide[ERR_OUT_BITS-1:0];
    return res;
  endfunction

  // Clean FM: every cell carries a clock in its high half
  function automatic logic [15:0] fm_encode(logic [7:0] data);
    logic [15:0] raw;
    for (int i = 0; i < 8; i++) raw[2*i +: 2] = data[i] ? CELL_ONE : CELL_CLK_LO;
    return raw;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
               out_beats, field, got, want);
  endtask

  task automatic push_word(logic [15:0] raw, logic first);
    fcpd_in_t w;
    w.raw_word   = raw;
    w.first_word = first;
    if (first) buffers++;
    pending_words.push_back(w);
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || issued != in_beats || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  // Random buffers: mostly clean FM, some damaged cells, slips and noise
  task automatic push_random_words(int unsigned count);
    int unsigned left;
    int unsigned pick;
    logic [15:0] raw;
    left = 0;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        raw = fm_encode(8'($urandom));
      end else if (pick < 70) begin
        raw = fm_encode(8'($urandom));
        raw[2*$urandom_range(0, 7) +: 2] = 2'($urandom);
      end else if (pick < 85) begin
        for (int i = 0; i < 8; i++)
          raw[2*i +: 2] = $urandom_range(0, 1) ? CELL_CLK_HI : CELL_CLK_LO;
      end else begin
        raw = 16'($urandom);
      end
      if (left == 0) left = $urandom_range(1, 40);
      push_word(raw, left == 40 || $urandom_range(0, 99) < 4 || n == 0);
      left--;
    end
  endtask

  // Cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_fm_cell_pair_decoder NOT OK");
      $finish;
    end
  end

  // Hold off the receiver once for a long stretch
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && in_beats >= HOLD_AT_BEAT) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end
    end
  end

  // Drive input beats at the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else if (issued == in_beats) begin
      if (pending_words.size() != 0 &&
          ((in_beats >= QUIET_FIRST && in_beats < QUIET_LAST) ||
           $urandom_range(0, 99) >= 33)) begin
        in_data_i  <= pending_words.pop_front();
        in_valid_i <= 1'b1;
        issued++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Drive output ready at the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
    end else if (in_beats >= QUIET_FIRST && in_beats < QUIET_LAST) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= 33);
    end
  end

  // Predict on input beats, check on output beats
  always @(posedge clk_i) begin
    fcpd_out_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(decode_word(in_data_i));
        in_beats <= in_beats + 1;
      end
      if (out_valid_o && out_ready_i) begin
        out_beats <= out_beats + 1;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected decoded_byte", 32'(out_data_o.decoded_byte), 32'(0));
        end else begin
          want = expected_results.pop_front();
          if (out_data_o.decoded_byte !== want.decoded_byte)
            report_mismatch("decoded_byte", 32'(out_data_o.decoded_byte),
                            32'(want.decoded_byte));
          if (out_data_o.zero_errors !== want.zero_errors)
            report_mismatch("zero_errors", 32'(out_data_o.zero_errors),
                            32'(want.zero_errors));
          if (out_data_o.one_errors !== want.one_errors)
            report_mismatch("one_errors", 32'(out_data_o.one_errors),
                            32'(want.one_errors));
        end
      end
    end
  end

  initial begin
    restart_buffer();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed words: all-zero and all-one cells, clean clocks, slips both ways
    push_word(16'h0000, 1'b0);
    push_word(16'hFFFF, 1'b0);
    push_word(16'hAAAA, 1'b1);
    push_word(16'h5555, 1'b0);
    push_word(16'h6666, 1'b0);
    push_word(16'h9999, 1'b1);
    push_word(16'hB4FF, 1'b1);
    push_word(16'hB4FF, 1'b0);
    push_word(16'h8000, 1'b1);
    push_word(16'h0001, 1'b0);
    push_word(16'h4000, 1'b0);
    push_word(fm_encode(8'hA5), 1'b1);
    push_word(fm_encode(8'h00), 1'b0);
    push_word(fm_encode(8'hFF), 1'b0);
    push_word(16'h1234, 1'b0);
    push_word(16'hEDCB, 1'b1);
    push_word(16'h0000, 1'b0);
    push_word(16'hFFFF, 1'b1);

    // Let everything drain, then run random buffers with one more pause
    wait_idle();
    push_random_words(RANDOM_WORDS / 2);
    wait_idle();
    push_random_words(RANDOM_WORDS - RANDOM_WORDS / 2);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d words in %0d buffers, %0d results checked",
             in_beats, buffers, out_beats);
    $display("clean FM, damaged cells, alignment slips and noise, with stalls on both sides");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_fm_cell_pair_decoder OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
      $display("tb_fm_cell_pair_decoder NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
rtl/fcpd_pkg.sv
rtl/fcpd_front.sv
rtl/fcpd_queue.sv
rtl/fcpd_back.sv
rtl/fm_cell_pair_decoder.sv
sim/tb_fm_cell_pair_decoder.sv
